// ----- rtl/core/pap_pkg.sv -----
package pap_pkg;

    localparam int TimeW  = 48;
    localparam int RateW  = 40;
    localparam int BurstW = 20;
    localparam int StartW = 24;
    localparam int TogW   = 32;
    localparam int BytesW = 16;

    localparam logic [1:0] REQ_SERVICE = 2'd0;
    localparam logic [1:0] REQ_OFFER   = 2'd1;
    localparam logic [1:0] REQ_EMPTY   = 2'd2;

    localparam logic [1:0] CFG_MIN_BURST = 2'd0;
    localparam logic [1:0] CFG_STARTUP   = 2'd1;
    localparam logic [1:0] CFG_START     = 2'd2;

    localparam logic [TimeW-1:0] TIME_MAX = {TimeW{1'b1}};
    localparam logic [23:0] SER_SCALE = 24'd8000000;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [TimeW-1:0]  now_us;
        logic [RateW-1:0]  new_rate_bps;
        logic [TimeW-1:0]  sched_svc_us;
        logic              queue_nonempty;
        logic              flow_halted;
        logic [BurstW-1:0] jitter_us;
        logic [BytesW-1:0] packet_bytes;
    } req_t;

    typedef struct packed {
        logic             admit;
        logic             window_open;
        logic [TimeW-1:0] next_admission_us;
        logic [TogW-1:0]  toggle_count;
        logic             push_stats;
        logic             flow_idle;
    } res_t;

    function automatic logic [TimeW-1:0] add_sat(input logic [TimeW-1:0] a,
                                                 input logic [TimeW-1:0] b);
        logic [TimeW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TimeW] ? TIME_MAX : s[TimeW-1:0];
    endfunction

    function automatic logic [TimeW-1:0] sub_sat(input logic [TimeW-1:0] a,
                                                 input logic [TimeW-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

// ----- rtl/core/pap_front.sv -----
module pap_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  pap_pkg::req_t   s_req,
    output logic            q_valid,
    input  logic            q_ready,
    output pap_pkg::req_t   q_req
);
    import pap_pkg::*;

    // two-entry queue, each slot holds one request word
    req_t mem_reg [2];
    logic wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop;

    assign s_tready = (cnt_reg != 2'd2);
    assign push = s_tvalid && s_tready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_req = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= s_req;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !pop) else $error("pop from empty queue");

endmodule

// ----- rtl/core/pap_muldiv.sv -----
// floor(a*b/d) saturated to 48 bits, restoring division one bit per cycle.
// Product formed from two 24x40 partials, low half of a then high, then 88 quotient bits.
module pap_muldiv (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pap_pkg::TimeW-1:0] a,
    input  logic [pap_pkg::RateW-1:0] b,
    input  logic [pap_pkg::RateW-1:0] d,
    output logic                      done,
    output logic [pap_pkg::TimeW-1:0] q
);
    import pap_pkg::*;

    localparam int PW = TimeW + RateW;
    localparam int CW = 7;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]      st_reg, st_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [PW-1:0]   prod_reg, prod_next;
    logic [TimeW-1:0] a_reg, a_next;
    logic [RateW-1:0] b_reg, b_next, d_reg, d_next;
    logic [RateW:0]  rem_reg, rem_next;
    logic [TimeW-1:0] q_reg, q_next;
    logic            over_reg, over_next;
    logic            done_reg, done_next;
    logic [RateW+23:0] part;
    logic [RateW:0]  sh;

    assign done = done_reg;
    assign q = over_reg ? TIME_MAX : q_reg;

    always_comb
    begin
        st_next = st_reg;
        cnt_next = cnt_reg;
        prod_next = prod_reg;
        a_next = a_reg;
        b_next = b_reg;
        d_next = d_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        over_next = over_reg;
        done_next = 1'b0;
        part = a_reg[23:0] * b_reg;
        sh = {rem_reg[RateW-1:0], prod_reg[PW-1]};
        case (st_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    a_next = a;
                    b_next = b;
                    d_next = d;
                    prod_next = '0;
                    cnt_next = '0;
                    st_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // two halves of a, low then high
                if (cnt_reg == '0)
                begin
                    prod_next = {{(PW-RateW-24){1'b0}}, part};
                    a_next = {24'd0, a_reg[TimeW-1:24]};
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    prod_next = prod_reg + {part[PW-25:0], 24'd0};
                    cnt_next = CW'(PW);
                    rem_next = '0;
                    q_next = '0;
                    over_next = 1'b0;
                    st_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                prod_next = {prod_reg[PW-2:0], 1'b0};
                if (sh >= {1'b0, d_reg})
                begin
                    rem_next = sh - {1'b0, d_reg};
                    if (cnt_reg > CW'(TimeW))
                        over_next = 1'b1;
                    q_next = {q_reg[TimeW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = sh;
                    q_next = {q_reg[TimeW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    st_next = ST_IDLE;
                    done_next = 1'b1;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        prod_reg <= prod_next;
        a_reg <= a_next;
        b_reg <= b_next;
        d_reg <= d_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        over_reg <= over_next;
    end

endmodule

// ----- rtl/core/pap_back.sv -----
module pap_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  pap_pkg::req_t              q_req,
    input  logic [pap_pkg::BurstW-1:0] min_burst,
    input  logic [pap_pkg::StartW-1:0] startup,
    input  logic [pap_pkg::TimeW-1:0]  start_time,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output pap_pkg::res_t              m_res
);
    import pap_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WAIT  = 3'd1;
    localparam logic [2:0] ST_FIN   = 3'd2;
    localparam logic [2:0] ST_OUT   = 3'd3;

    logic [2:0]       st_reg, st_next;
    req_t             r_reg, r_next;
    logic [TimeW-1:0] nat_reg, nat_next, bet_reg, bet_next;
    logic [RateW-1:0] rate_reg, rate_next;
    logic [TogW-1:0]  tog_reg, tog_next;
    logic             stat_reg, stat_next, idle_reg, idle_next;
    logic             adm_reg, adm_next;
    logic             ov_reg, ov_next;
    res_t             out_reg, out_next;

    logic             md_start, md_done;
    logic [TimeW-1:0] md_a, md_q, low, tnat;
    logic [RateW-1:0] md_b, md_d;
    logic             win;

    pap_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .a     (md_a),
        .b     (md_b),
        .d     (md_d),
        .done  (md_done),
        .q     (md_q)
    );

    assign q_ready = (st_reg == ST_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_res = out_reg;
    assign win = (rate_reg != '0) && (nat_reg <= bet_reg);

    always_comb
    begin
        st_next = st_reg;
        r_next = r_reg;
        nat_next = nat_reg;
        bet_next = bet_reg;
        rate_next = rate_reg;
        tog_next = tog_reg;
        stat_next = stat_reg;
        idle_next = idle_reg;
        adm_next = adm_reg;
        ov_next = ov_reg && !m_tready;
        out_next = out_reg;
        md_start = 1'b0;
        md_a = nat_reg - q_req.sched_svc_us;
        md_b = rate_reg;
        md_d = q_req.new_rate_bps;
        low = sub_sat(r_reg.now_us, {{(TimeW-BurstW){1'b0}}, min_burst});
        tnat = nat_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (q_valid && q_ready)
                begin
                    r_next = q_req;
                    adm_next = 1'b0;
                    st_next = ST_FIN;
                    case (q_req.req_type)
                        REQ_SERVICE:
                        begin
                            stat_next = 1'b0;
                            if (q_req.new_rate_bps == '0 && rate_reg != '0)
                            begin
                                if (q_req.queue_nonempty && !q_req.flow_halted)
                                begin
                                    tog_next = tog_reg + 1'b1;
                                    stat_next = 1'b1;
                                end
                            end
                            else if (q_req.new_rate_bps != '0 && rate_reg == '0 &&
                                     start_time < sub_sat(q_req.now_us,
                                         {{(TimeW-StartW){1'b0}}, startup}))
                            begin
                                tog_next = tog_reg + 1'b1;
                                stat_next = 1'b1;
                            end
                            if (nat_reg > q_req.sched_svc_us && q_req.new_rate_bps != '0)
                            begin
                                md_start = 1'b1;
                                st_next = ST_WAIT;
                            end
                        end
                        REQ_OFFER:
                        begin
                            if (win)
                            begin
                                if (q_req.packet_bytes == '0)
                                    idle_next = 1'b1;
                                else
                                begin
                                    md_a = {{(TimeW-BytesW){1'b0}}, q_req.packet_bytes};
                                    md_b = {{(RateW-24){1'b0}}, SER_SCALE};
                                    md_d = rate_reg;
                                    md_start = 1'b1;
                                    st_next = ST_WAIT;
                                end
                            end
                        end
                        REQ_EMPTY: idle_next = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_WAIT:
            begin
                if (md_done)
                begin
                    if (r_reg.req_type == REQ_SERVICE)
                        nat_next = add_sat(r_reg.sched_svc_us, md_q);
                    else
                    begin
                        adm_next = 1'b1;
                        idle_next = 1'b0;
                        nat_next = idle_reg ? add_sat(r_reg.now_us, md_q)
                                            : add_sat(nat_reg, md_q);
                    end
                    st_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (r_reg.req_type == REQ_SERVICE)
                begin
                    rate_next = r_reg.new_rate_bps;
                    if (r_reg.new_rate_bps != '0)
                    begin
                        if (nat_reg < low)
                            tnat = low;
                        nat_next = tnat;
                        bet_next = add_sat(add_sat(r_reg.now_us,
                                       {{(TimeW-BurstW){1'b0}}, min_burst}),
                                       {{(TimeW-BurstW){1'b0}}, r_reg.jitter_us});
                    end
                end
                st_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg || m_tready)
                begin
                    out_next.admit = adm_reg;
                    out_next.window_open = win;
                    out_next.next_admission_us = nat_reg;
                    out_next.toggle_count = tog_reg;
                    out_next.push_stats = stat_reg;
                    out_next.flow_idle = idle_reg;
                    ov_next = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            nat_reg <= '0;
            bet_reg <= '0;
            rate_reg <= '0;
            tog_reg <= '0;
            stat_reg <= 1'b0;
            idle_reg <= 1'b1;
            adm_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            nat_reg <= nat_next;
            bet_reg <= bet_next;
            rate_reg <= rate_next;
            tog_reg <= tog_next;
            stat_reg <= stat_next;
            idle_reg <= idle_next;
            adm_reg <= adm_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        out_reg <= out_next;
    end

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |-> st_reg == ST_IDLE) else $error("take while busy");
    a_admit_rate: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_res.admit |-> !m_res.flow_idle) else $error("admit while idle");
    a_stat_tog: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stat_reg) |-> tog_reg != $past(tog_reg)) else $error("stat without toggle");

endmodule

// ----- rtl/core/packet_admission_pacer_unit.sv -----
// Virtual-time packet pacer for one flow. Each word on s_axis is a request
// (service event, packet offer, queue empty); each yields exactly one result
// word on m_axis. Requests are queued two deep in front of the execution
// engine, so the input side takes up to two words while the engine is busy.
// Service events that rescale and admitted offers go through a shared
// restoring multiply-divide unit: two multiply steps, 88 quotient bits,
// then the FIN and OUT states; other requests skip it. The user must issue
// configuration writes on cfg_* only while idle; the block does not check it.
module packet_admission_pacer_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: now_us[47:0], new_rate_bps[87:48], sched_svc_us[135:88],
    // queue_nonempty[136], flow_halted[137], jitter_us[157:138],
    // packet_bytes[173:158], zero pad to 176
    input  logic [175:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: admit[0], window_open[1], next_admission_us[49:2],
    // toggle_count[81:50], push_stats[82], flow_idle[83], zero pad to 88
    output logic [87:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_data
);
    import pap_pkg::*;

    req_t  s_req, q_req;
    res_t  res;
    logic  q_valid, q_ready;
    logic [BurstW-1:0] min_burst_reg;
    logic [StartW-1:0] startup_reg;
    logic [TimeW-1:0]  start_reg;

    assign s_req.req_type       = s_axis_tuser;
    assign s_req.now_us         = s_axis_tdata[47:0];
    assign s_req.new_rate_bps   = s_axis_tdata[87:48];
    assign s_req.sched_svc_us   = s_axis_tdata[135:88];
    assign s_req.queue_nonempty = s_axis_tdata[136];
    assign s_req.flow_halted    = s_axis_tdata[137];
    assign s_req.jitter_us      = s_axis_tdata[157:138];
    assign s_req.packet_bytes   = s_axis_tdata[173:158];

    assign m_axis_tdata = {4'd0, res.flow_idle, res.push_stats, res.toggle_count,
                           res.next_admission_us, res.window_open, res.admit};
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_burst_reg <= BurstW'(5000);
            startup_reg <= StartW'(1000000);
            start_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_BURST: min_burst_reg <= cfg_data[BurstW-1:0];
                CFG_STARTUP:   startup_reg <= cfg_data[StartW-1:0];
                CFG_START:     start_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    pap_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_req    (s_req),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    pap_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_req      (q_req),
        .min_burst  (min_burst_reg),
        .startup    (startup_reg),
        .start_time (start_reg),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_res      (res)
    );

endmodule
